// ===== sv/mstw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstw_pkg: shared types and constants
// Widths, item kinds, memory entry layouts and back-end states of the
// minimum spanning tree weight block.
// ----------------------------------------------------------------------------
package mstw_pkg;

    localparam int VTX_BITS    = 7;
    localparam int MAX_VERTICES = 64;
    localparam int KEY_AW      = 6;
    localparam int MAX_EDGES   = 256;
    localparam int EDGE_AW     = 8;
    localparam int FILL_BITS   = 9;
    localparam int WEIGHT_BITS = 16;
    localparam int KEY_BITS    = 17;
    localparam int TOTAL_BITS  = 22;
    localparam int ACC_BITS    = 24;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;

    localparam logic signed [KEY_BITS-1:0] KEY_INF  = 17'sd32768;
    localparam logic signed [ACC_BITS-1:0] TOTAL_HI = 24'sd2097151;
    localparam logic signed [ACC_BITS-1:0] TOTAL_LO = -24'sd2097152;

    typedef enum logic [1:0] {
        K_EDGE,
        K_DROP,
        K_FINISH
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [VTX_BITS-1:0]     a;
        logic [VTX_BITS-1:0]     b;
        logic [WEIGHT_BITS-1:0]  w;
    } t_cmd;

    typedef struct packed {
        logic [VTX_BITS-1:0]     a;
        logic [VTX_BITS-1:0]     b;
        logic [WEIGHT_BITS-1:0]  w;
    } t_edge;

    typedef struct packed {
        logic                    in_tree;
        logic [KEY_BITS-1:0]     key;
    } t_key;

    typedef enum logic [3:0] {
        B_IDLE,
        B_INIT,
        B_SCAN_RD,
        B_SCAN_CHK,
        B_MARK,
        B_EDGE_RD,
        B_EDGE_CHK,
        B_KEY_CHK,
        B_DONE
    } t_bstate;

endpackage
`default_nettype wire

// ===== sv/mstw_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstw_ram: generic memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mstw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== sv/mstw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstw_front: item intake and classification
// Checks edge endpoints against the vertex count and queues each item,
// tagged as a stored edge, a dropped edge or a finish, for the back end.
// ----------------------------------------------------------------------------
module mstw_front
    import mstw_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   i_mode,
    input  wire logic [VTX_BITS-1:0]    i_end_a,
    input  wire logic [VTX_BITS-1:0]    i_end_b,
    input  wire logic [WEIGHT_BITS-1:0] i_edge_weight,
    input  wire logic [VTX_BITS-1:0]    i_vlimit,
    input  wire logic                   i_q_pop,
    output logic                        o_q_empty,
    output t_cmd                        o_q_head
);

    t_cmd             r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_cnt;
    t_cmd             w_cmd;
    logic             w_push, w_pop, w_bad;

    assign full      = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_q_empty = (r_cnt == '0);
    assign o_q_head  = r_q[r_rp];
    assign w_push    = push && !full;
    assign w_pop     = i_q_pop && !o_q_empty;

    always_comb begin
        w_bad = (i_end_a == '0) || (i_end_b == '0) ||
                (i_end_a > i_vlimit) || (i_end_b > i_vlimit);
        w_cmd.a = i_end_a;
        w_cmd.b = i_end_b;
        w_cmd.w = i_edge_weight;
        if (i_mode) begin
            w_cmd.kind = K_FINISH;
        end else if (w_bad) begin
            w_cmd.kind = K_DROP;
        end else begin
            w_cmd.kind = K_EDGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/mstw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstw_back: edge store and tree growth
// Stores edges, and on a finish item grows the tree from vertex 1 by
// alternating a key scan over the vertices with an edge relaxation pass.
// ----------------------------------------------------------------------------
module mstw_back
    import mstw_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [VTX_BITS-1:0]    i_vlimit,
    input  wire logic                   i_q_empty,
    input  wire t_cmd                   i_q_head,
    output logic                        o_q_pop,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [TOTAL_BITS-1:0]       o_total_weight,
    output logic                        o_edges_dropped
);

    t_bstate                r_state, n_state;
    logic [FILL_BITS-1:0]   r_fill, n_fill;
    logic                   r_drop_flag, n_drop_flag;
    logic [KEY_AW-1:0]      r_idx, n_idx;
    logic [VTX_BITS-1:0]    r_v, n_v;
    logic                   r_found, n_found;
    logic [VTX_BITS-1:0]    r_pick, n_pick;
    logic [KEY_BITS-1:0]    r_pick_key, n_pick_key;
    logic [ACC_BITS-1:0]    r_acc, n_acc;
    logic [FILL_BITS-1:0]   r_e, n_e;
    logic [VTX_BITS-1:0]    r_y, n_y;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic                   r_out_valid, n_out_valid;
    logic [TOTAL_BITS-1:0]  r_total, n_total;
    logic                   r_out_drop, n_out_drop;

    logic                   w_ewe, w_kwe;
    logic [EDGE_AW-1:0]     w_ewaddr;
    t_edge                  w_ewdata, w_erdata;
    logic [KEY_AW-1:0]      w_kwaddr, w_kraddr;
    t_key                   w_kwdata, w_krdata;

    logic                   w_cand, w_hit_a, w_hit, w_last, w_relax;
    logic [VTX_BITS-1:0]    w_y, w_ym1, w_vm1, w_pm1;
    logic [KEY_BITS-1:0]    w_wext;
    logic [ACC_BITS-1:0]    w_sum;

    mstw_ram #(.WIDTH($bits(t_edge)), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk   (i_clk),
        .i_we    (w_ewe),
        .i_waddr (w_ewaddr),
        .i_wdata (w_ewdata),
        .i_raddr (r_e[EDGE_AW-1:0]),
        .o_rdata (w_erdata)
    );

    mstw_ram #(.WIDTH($bits(t_key)), .DEPTH(MAX_VERTICES)) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_kwe),
        .i_waddr (w_kwaddr),
        .i_wdata (w_kwdata),
        .i_raddr (w_kraddr),
        .o_rdata (w_krdata)
    );

    assign empty           = !r_out_valid;
    assign o_total_weight  = r_total;
    assign o_edges_dropped = r_out_drop;

    always_comb begin
        w_cand  = !w_krdata.in_tree && (w_krdata.key != KEY_INF) &&
                  (!r_found || ($signed(w_krdata.key) < $signed(r_pick_key)));
        w_hit_a = (w_erdata.a == r_pick);
        w_y     = w_hit_a ? w_erdata.b : w_erdata.a;
        w_hit   = (w_erdata.a <= i_vlimit) && (w_erdata.b <= i_vlimit) &&
                  (w_hit_a || (w_erdata.b == r_pick));
        w_last  = ((r_e + 1'b1) == r_fill);
        w_wext  = {r_w[WEIGHT_BITS-1], r_w};
        w_relax = !w_krdata.in_tree && ($signed(w_wext) < $signed(w_krdata.key));
        w_ym1   = w_y - 1'b1;
        w_vm1   = r_v - 1'b1;
        w_pm1   = r_pick - 1'b1;
        w_sum   = r_acc + {{(ACC_BITS-KEY_BITS){r_pick_key[KEY_BITS-1]}}, r_pick_key};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty && (i_q_head.kind == K_FINISH)) begin
                    n_state = B_INIT;
                end
            end
            B_INIT: begin
                if (r_idx == KEY_AW'(MAX_VERTICES - 1)) begin
                    n_state = B_SCAN_RD;
                end
            end
            B_SCAN_RD: n_state = B_SCAN_CHK;
            B_SCAN_CHK: begin
                if (r_v == i_vlimit) begin
                    n_state = (r_found || w_cand) ? B_MARK : B_DONE;
                end else begin
                    n_state = B_SCAN_RD;
                end
            end
            B_MARK: begin
                n_state = (r_fill == '0) ? B_SCAN_RD : B_EDGE_RD;
            end
            B_EDGE_RD: n_state = B_EDGE_CHK;
            B_EDGE_CHK: begin
                if (w_hit) begin
                    n_state = B_KEY_CHK;
                end else begin
                    n_state = w_last ? B_SCAN_RD : B_EDGE_RD;
                end
            end
            B_KEY_CHK: n_state = w_last ? B_SCAN_RD : B_EDGE_RD;
            B_DONE: begin
                if (!r_out_valid || pop) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_fill      = r_fill;
        n_drop_flag = r_drop_flag;
        n_idx       = r_idx;
        n_v         = r_v;
        n_found     = r_found;
        n_pick      = r_pick;
        n_pick_key  = r_pick_key;
        n_acc       = r_acc;
        n_e         = r_e;
        n_y         = r_y;
        n_w         = r_w;
        n_out_valid = r_out_valid && !pop;
        n_total     = r_total;
        n_out_drop  = r_out_drop;
        o_q_pop     = 1'b0;
        w_ewe       = 1'b0;
        w_ewaddr    = r_fill[EDGE_AW-1:0];
        w_ewdata.a  = i_q_head.a;
        w_ewdata.b  = i_q_head.b;
        w_ewdata.w  = i_q_head.w;
        w_kwe       = 1'b0;
        w_kwaddr    = r_idx;
        w_kwdata    = '{in_tree: 1'b0, key: KEY_INF};
        w_kraddr    = w_vm1[KEY_AW-1:0];
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    case (i_q_head.kind)
                        K_EDGE: begin
                            if (r_fill == FILL_BITS'(MAX_EDGES)) begin
                                n_drop_flag = 1'b1;
                            end else begin
                                w_ewe  = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        K_DROP: n_drop_flag = 1'b1;
                        K_FINISH: begin
                            n_acc = '0;
                            n_idx = '0;
                        end
                        default: n_drop_flag = r_drop_flag;
                    endcase
                end
            end
            B_INIT: begin
                w_kwe = 1'b1;
                if (r_idx == '0) begin
                    w_kwdata.key = '0;
                end
                n_idx = r_idx + 1'b1;
            end
            B_SCAN_RD: begin
                w_kraddr = w_vm1[KEY_AW-1:0];
            end
            B_SCAN_CHK: begin
                if (w_cand) begin
                    n_found    = 1'b1;
                    n_pick     = r_v;
                    n_pick_key = w_krdata.key;
                end
                n_v = r_v + 1'b1;
            end
            B_MARK: begin
                w_kwe    = 1'b1;
                w_kwaddr = w_pm1[KEY_AW-1:0];
                w_kwdata = '{in_tree: 1'b1, key: r_pick_key};
                n_acc    = w_sum;
                n_e      = '0;
            end
            B_EDGE_CHK: begin
                w_kraddr = w_ym1[KEY_AW-1:0];
                n_y      = w_y;
                n_w      = w_erdata.w;
                if (!w_hit) begin
                    n_e = r_e + 1'b1;
                end
            end
            B_KEY_CHK: begin
                w_kwaddr = w_ym1[KEY_AW-1:0];
                w_kwaddr = KEY_AW'(r_y - 1'b1);
                w_kwdata = '{in_tree: 1'b0, key: w_wext};
                w_kwe    = w_relax;
                n_e      = r_e + 1'b1;
            end
            B_DONE: begin
                if (!r_out_valid || pop) begin
                    n_out_valid = 1'b1;
                    if ($signed(r_acc) > $signed(TOTAL_HI)) begin
                        n_total = TOTAL_HI[TOTAL_BITS-1:0];
                    end else if ($signed(r_acc) < $signed(TOTAL_LO)) begin
                        n_total = TOTAL_LO[TOTAL_BITS-1:0];
                    end else begin
                        n_total = r_acc[TOTAL_BITS-1:0];
                    end
                    n_out_drop  = r_drop_flag;
                    n_fill      = '0;
                    n_drop_flag = 1'b0;
                end
            end
            default: n_e = r_e;
        endcase
        if ((n_state == B_SCAN_RD) && (r_state != B_SCAN_CHK)) begin
            n_v     = VTX_BITS'(1);
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_v        <= n_v;
        r_found    <= n_found;
        r_pick     <= n_pick;
        r_pick_key <= n_pick_key;
        r_acc      <= n_acc;
        r_e        <= n_e;
        r_y        <= n_y;
        r_w        <= n_w;
        r_total    <= n_total;
        r_out_drop <= n_out_drop;
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_fill      <= '0;
            r_drop_flag <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_drop_flag <= n_drop_flag;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== sv/min_spanning_tree_weight.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_spanning_tree_weight: minimum spanning tree weight by Prim's method
// Loads weighted edges, then on a finish item reports the tree weight of
// vertex 1's component and whether any edge was dropped.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     push / full               i_mode, i_end_a, i_end_b, i_edge_weight
// result    empty / pop               o_total_weight, o_edges_dropped
// config    i_cfg_valid / o_cfg_ready i_cfg_data (vertex count)
//
// Edge items are taken one per cycle through a four-entry queue while the back end is idle.
// A finish leaves the queue and the whole key memory is set up; then per tree
// vertex each vertex is read and checked, the pick is marked, and each stored
// edge is read and checked, with a key check on a hit; then a closing scan runs
// and the result is posted. The registered memory reads need the read steps.
// Reset is synchronous and active low; the graph is empty after it.
// A result left waiting stalls the back end only when the next finish is
// ready to post, and then items behind it wait in the queue, which raises full.
// ----------------------------------------------------------------------------
module min_spanning_tree_weight
    import mstw_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   i_mode,
    input  wire logic [VTX_BITS-1:0]    i_end_a,
    input  wire logic [VTX_BITS-1:0]    i_end_b,
    input  wire logic [WEIGHT_BITS-1:0] i_edge_weight,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [TOTAL_BITS-1:0]       o_total_weight,
    output logic                        o_edges_dropped,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [VTX_BITS-1:0]    i_cfg_data
);

    logic [VTX_BITS-1:0] r_vcount;
    logic [VTX_BITS-1:0] w_vlimit;
    logic                w_q_empty, w_q_pop;
    t_cmd                w_q_head;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_vcount == '0) begin
            w_vlimit = VTX_BITS'(1);
        end else if (r_vcount > VTX_BITS'(MAX_VERTICES)) begin
            w_vlimit = VTX_BITS'(MAX_VERTICES);
        end else begin
            w_vlimit = r_vcount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VTX_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vcount <= i_cfg_data;
        end
    end

    mstw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_end_a       (i_end_a),
        .i_end_b       (i_end_b),
        .i_edge_weight (i_edge_weight),
        .i_vlimit      (w_vlimit),
        .i_q_pop       (w_q_pop),
        .o_q_empty     (w_q_empty),
        .o_q_head      (w_q_head)
    );

    mstw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vlimit        (w_vlimit),
        .i_q_empty       (w_q_empty),
        .i_q_head        (w_q_head),
        .o_q_pop         (w_q_pop),
        .empty           (empty),
        .pop             (pop),
        .o_total_weight  (o_total_weight),
        .o_edges_dropped (o_edges_dropped)
    );

endmodule
`default_nettype wire
